@@ rtl/triad_attitude_matrix_top_macros.svh @@
// assertion macros for the triad attitude matrix block
`ifndef TRIAD_ATTITUDE_MATRIX_TOP_MACROS_SVH
`define TRIAD_ATTITUDE_MATRIX_TOP_MACROS_SVH

// property checked on every clock edge outside reset
`define TAM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition in one cycle implies a consequence in the next
`define TAM_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

@@ rtl/tam_pkg.sv @@
// shared widths, types and the normaliser latency of the triad attitude matrix block
package tam_pkg;

  localparam int unsigned Q14_W    = 16;
  localparam int unsigned CROSS_W  = 2 * Q14_W + 1;
  localparam int unsigned NORM_LAT = 57;

  typedef logic signed [Q14_W-1:0]   q14_t;
  typedef logic signed [CROSS_W-1:0] cross_t;

endpackage

@@ rtl/tam_dly.sv @@
// delay line with stall enable
module tam_dly #(
  parameter int unsigned W = 1,
  parameter int unsigned N = 1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] stage_q [N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N; i++) stage_q[i] <= '0;
    end else if (en_i) begin
      stage_q[0] <= d_i;
      for (int i = 1; i < N; i++) stage_q[i] <= stage_q[i-1];
    end
  end

  assign q_o = stage_q[N-1];

endmodule

@@ rtl/tam_norm.sv @@
// pipelined vector normaliser: scale, sum of squares, square root, divide
module tam_norm (
  input  logic            clk_i,
  input  logic            en_i,
  input  tam_pkg::cross_t vec_i  [3],
  output tam_pkg::q14_t   axis_o [3]
);
  import tam_pkg::*;

  localparam int unsigned MAG_W    = CROSS_W - 1;
  localparam int unsigned SC_W     = MAG_W - 2;
  localparam int unsigned SQ_W     = 2 * SC_W;
  localparam int unsigned SUM_W    = SQ_W + 2;
  localparam int unsigned ROOT_W   = SUM_W / 2;
  localparam int unsigned FRAC     = Q14_W - 2;
  localparam int unsigned NUM_W    = SC_W + FRAC + 1;
  localparam int unsigned QUO_W    = FRAC + 1;
  localparam int unsigned SH_STEPS = $clog2(MAG_W);

  typedef struct packed {
    logic [2:0][SC_W-1:0] mag;
    logic [2:0]           neg;
    logic                 zero;
  } side_t;

  // magnitudes and signs
  logic [MAG_W-1:0] mag_q [3];
  logic [2:0]       neg_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        neg_q[i] <= vec_i[i][CROSS_W-1];
        mag_q[i] <= vec_i[i][CROSS_W-1] ? MAG_W'(-vec_i[i]) : MAG_W'(vec_i[i]);
      end
    end
  end

  // largest magnitude, then left justify in binary steps
  logic [MAG_W-1:0]  m_d;
  logic [MAG_W-1:0]  sh_m_q   [SH_STEPS+1];
  logic [MAG_W-1:0]  sh_mag_q [SH_STEPS+1][3];
  logic [2:0]        sh_neg_q [SH_STEPS+1];
  logic [SH_STEPS:0] sh_zero_q;

  always_comb begin
    m_d = mag_q[0];
    if (mag_q[1] > m_d) m_d = mag_q[1];
    if (mag_q[2] > m_d) m_d = mag_q[2];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sh_m_q[0]    <= m_d;
      sh_mag_q[0]  <= mag_q;
      sh_neg_q[0]  <= neg_q;
      sh_zero_q[0] <= (m_d == '0);
    end
  end

  for (genvar s = 1; s <= SH_STEPS; s++) begin : g_shift
    localparam int unsigned AMT = 2 ** (SH_STEPS - s);
    logic top_zero;
    assign top_zero = (sh_m_q[s-1][MAG_W-1 -: AMT] == '0);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sh_neg_q[s]  <= sh_neg_q[s-1];
        sh_zero_q[s] <= sh_zero_q[s-1];
        if (top_zero) begin
          sh_m_q[s] <= sh_m_q[s-1] << AMT;
          for (int i = 0; i < 3; i++) sh_mag_q[s][i] <= sh_mag_q[s-1][i] << AMT;
        end else begin
          sh_m_q[s]   <= sh_m_q[s-1];
          sh_mag_q[s] <= sh_mag_q[s-1];
        end
      end
    end
  end

  // leading one now at the top bit: drop two bits so it sits at bit 29
  side_t            sc_side;
  side_t            sq_side_q;
  logic [SQ_W-1:0]  sq_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) sc_side.mag[i] = sh_mag_q[SH_STEPS][i][MAG_W-1:2];
    sc_side.neg  = sh_neg_q[SH_STEPS];
    sc_side.zero = sh_zero_q[SH_STEPS];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_side_q <= sc_side;
      for (int i = 0; i < 3; i++) sq_q[i] <= sc_side.mag[i] * sc_side.mag[i];
    end
  end

  // square root, one result bit per stage
  logic [SUM_W-1:0]  rt_rem_q  [ROOT_W+1];
  logic [ROOT_W-1:0] rt_res_q  [ROOT_W+1];
  side_t             rt_side_q [ROOT_W+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rt_rem_q[0]  <= SUM_W'(sq_q[0]) + SUM_W'(sq_q[1]) + SUM_W'(sq_q[2]);
      rt_res_q[0]  <= '0;
      rt_side_q[0] <= sq_side_q;
    end
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_root
    localparam int unsigned B = ROOT_W - 1 - k;
    logic [SUM_W+1:0] trial;
    logic             fit;
    assign trial = ((SUM_W+2)'(rt_res_q[k]) << (B + 1)) + ((SUM_W+2)'(1) << (2 * B));
    assign fit   = ({2'b00, rt_rem_q[k]} >= trial);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rt_side_q[k+1] <= rt_side_q[k];
        rt_rem_q[k+1]  <= fit ? rt_rem_q[k] - trial[SUM_W-1:0] : rt_rem_q[k];
        rt_res_q[k+1]  <= fit ? rt_res_q[k] | (ROOT_W'(1) << B) : rt_res_q[k];
      end
    end
  end

  // rounded division, one quotient bit per stage
  logic [NUM_W-1:0]  dv_rem_q  [QUO_W+1][3];
  logic [QUO_W-1:0]  dv_quo_q  [QUO_W+1][3];
  logic [ROOT_W-1:0] dv_n_q    [QUO_W+1];
  logic [2:0]        dv_neg_q  [QUO_W+1];
  logic [QUO_W:0]    dv_zero_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        dv_rem_q[0][i] <= NUM_W'({rt_side_q[ROOT_W].mag[i], {FRAC{1'b0}}})
                        + NUM_W'(rt_res_q[ROOT_W] >> 1);
        dv_quo_q[0][i] <= '0;
      end
      dv_n_q[0]    <= rt_res_q[ROOT_W];
      dv_neg_q[0]  <= rt_side_q[ROOT_W].neg;
      dv_zero_q[0] <= rt_side_q[ROOT_W].zero;
    end
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    localparam int unsigned B = QUO_W - 1 - k;
    logic [NUM_W:0] dsr;
    assign dsr = (NUM_W+1)'(dv_n_q[k]) << B;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_n_q[k+1]    <= dv_n_q[k];
        dv_neg_q[k+1]  <= dv_neg_q[k];
        dv_zero_q[k+1] <= dv_zero_q[k];
        for (int i = 0; i < 3; i++) begin
          if ({1'b0, dv_rem_q[k][i]} >= dsr) begin
            dv_rem_q[k+1][i] <= dv_rem_q[k][i] - dsr[NUM_W-1:0];
            dv_quo_q[k+1][i] <= dv_quo_q[k][i] | (QUO_W'(1) << B);
          end else begin
            dv_rem_q[k+1][i] <= dv_rem_q[k][i];
            dv_quo_q[k+1][i] <= dv_quo_q[k][i];
          end
        end
      end
    end
  end

  // sign back on, zero vector gives zero axis
  q14_t axis_q [3];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        if (dv_zero_q[QUO_W]) begin
          axis_q[i] <= '0;
        end else if (dv_neg_q[QUO_W][i]) begin
          axis_q[i] <= q14_t'(-Q14_W'(dv_quo_q[QUO_W][i]));
        end else begin
          axis_q[i] <= q14_t'(Q14_W'(dv_quo_q[QUO_W][i]));
        end
      end
    end
  end

  assign axis_o = axis_q;

endmodule

@@ rtl/triad_attitude_matrix_top.sv @@
// triad attitude matrix: two vector pairs in, rotation matrix out
// throughput: one transfer per cycle while the output is not stalled, the whole pipeline advances together
// each normaliser holds a 31-stage square root and a 15-stage divider
// a stalled output freezes every stage, nothing is dropped or repeated
// reset clears all valid bits; data registers carry no reset, except those in the delay lines
module triad_attitude_matrix_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  tam_pkg::q14_t obs_first_x_i,
  input  tam_pkg::q14_t obs_first_y_i,
  input  tam_pkg::q14_t obs_first_z_i,
  input  tam_pkg::q14_t obs_second_x_i,
  input  tam_pkg::q14_t obs_second_y_i,
  input  tam_pkg::q14_t obs_second_z_i,
  input  tam_pkg::q14_t ref_first_x_i,
  input  tam_pkg::q14_t ref_first_y_i,
  input  tam_pkg::q14_t ref_first_z_i,
  input  tam_pkg::q14_t ref_second_x_i,
  input  tam_pkg::q14_t ref_second_y_i,
  input  tam_pkg::q14_t ref_second_z_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output tam_pkg::q14_t rot_00_o,
  output tam_pkg::q14_t rot_01_o,
  output tam_pkg::q14_t rot_02_o,
  output tam_pkg::q14_t rot_10_o,
  output tam_pkg::q14_t rot_11_o,
  output tam_pkg::q14_t rot_12_o,
  output tam_pkg::q14_t rot_20_o,
  output tam_pkg::q14_t rot_21_o,
  output tam_pkg::q14_t rot_22_o,
  output logic          degenerate_o
);
  import tam_pkg::*;

  localparam int unsigned PROD_W = 2 * Q14_W;
  localparam int unsigned ACC_W  = PROD_W + 2;
  localparam int unsigned RND_W  = ACC_W - (Q14_W - 2);
  localparam int unsigned FLAT_W = 2 * 2 * 3 * Q14_W;

  // round a q6.28 sum to q2.14, ties away from zero, then clip
  function automatic q14_t round_sat(input logic signed [ACC_W-1:0] s);
    logic [ACC_W-1:0] mag;
    logic [RND_W-1:0] q;
    q14_t             r;
    mag = s[ACC_W-1] ? ACC_W'(-s) : ACC_W'(s);
    q   = RND_W'((mag + (ACC_W'(1) << (Q14_W - 3))) >> (Q14_W - 2));
    if (!s[ACC_W-1]) begin
      r = (q > RND_W'(16'h7fff)) ? q14_t'(16'h7fff) : q14_t'(q[Q14_W-1:0]);
    end else begin
      r = (q > RND_W'(16'h8000)) ? q14_t'(16'h8000) : q14_t'(~q[Q14_W-1:0] + 16'd1);
    end
    return r;
  endfunction

  // whole pipeline moves unless a finished result is waiting
  logic en;
  logic out_vld_q;

  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  // frame 0 is the observed pair, frame 1 the catalog pair
  q14_t v1_in [2][3];
  q14_t v2_in [2][3];

  assign v1_in[0] = '{obs_first_x_i, obs_first_y_i, obs_first_z_i};
  assign v2_in[0] = '{obs_second_x_i, obs_second_y_i, obs_second_z_i};
  assign v1_in[1] = '{ref_first_x_i, ref_first_y_i, ref_first_z_i};
  assign v2_in[1] = '{ref_second_x_i, ref_second_y_i, ref_second_z_i};

  // stage a: the six partial products of each input cross product
  logic signed [PROD_W-1:0] a_prod_q [2][6];
  q14_t                     a_v1_q   [2][3];
  logic                     a_vld_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int f = 0; f < 2; f++) begin
        a_prod_q[f][0] <= v1_in[f][1] * v2_in[f][2];
        a_prod_q[f][1] <= v1_in[f][2] * v2_in[f][1];
        a_prod_q[f][2] <= v1_in[f][2] * v2_in[f][0];
        a_prod_q[f][3] <= v1_in[f][0] * v2_in[f][2];
        a_prod_q[f][4] <= v1_in[f][0] * v2_in[f][1];
        a_prod_q[f][5] <= v1_in[f][1] * v2_in[f][0];
        a_v1_q[f]      <= v1_in[f];
      end
    end
  end

  // stage b: cross products and the degenerate test
  cross_t b_cr_q [2][3];
  cross_t b_v1_q [2][3];
  logic   b_deg_q;
  logic   b_vld_q;
  logic   cross_zero [2];

  always_comb begin
    for (int f = 0; f < 2; f++) begin
      cross_zero[f] = (a_prod_q[f][0] == a_prod_q[f][1])
                   && (a_prod_q[f][2] == a_prod_q[f][3])
                   && (a_prod_q[f][4] == a_prod_q[f][5]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int f = 0; f < 2; f++) begin
        for (int c = 0; c < 3; c++) begin
          b_cr_q[f][c] <= CROSS_W'(a_prod_q[f][2*c]) - CROSS_W'(a_prod_q[f][2*c+1]);
          b_v1_q[f][c] <= CROSS_W'(a_v1_q[f][c]);
        end
      end
      b_deg_q <= cross_zero[0] || cross_zero[1];
    end
  end

  // first, second and third triad axes of both frames
  q14_t ax0 [2][3];
  q14_t ax1 [2][3];
  q14_t ax2 [2][3];

  logic [1:0] n1_ctl;

  tam_dly #(
    .W (2),
    .N (NORM_LAT)
  ) u_dly_ctl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .d_i    ({b_vld_q, b_deg_q}),
    .q_o    (n1_ctl)
  );

  // stage c: products for the third axis
  logic signed [PROD_W-1:0] c_prod_q [2][6];
  q14_t                     c_ax_q   [2][2][3];
  logic                     c_deg_q;
  logic                     c_vld_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int f = 0; f < 2; f++) begin
        c_prod_q[f][0] <= ax0[f][1] * ax1[f][2];
        c_prod_q[f][1] <= ax0[f][2] * ax1[f][1];
        c_prod_q[f][2] <= ax0[f][2] * ax1[f][0];
        c_prod_q[f][3] <= ax0[f][0] * ax1[f][2];
        c_prod_q[f][4] <= ax0[f][0] * ax1[f][1];
        c_prod_q[f][5] <= ax0[f][1] * ax1[f][0];
        c_ax_q[f][0]   <= ax0[f];
        c_ax_q[f][1]   <= ax1[f];
      end
      c_deg_q <= n1_ctl[0];
    end
  end

  // stage d: third axis cross products
  cross_t d_cr_q [2][3];
  q14_t   d_ax_q [2][2][3];
  logic   d_deg_q;
  logic   d_vld_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int f = 0; f < 2; f++) begin
        for (int c = 0; c < 3; c++) begin
          d_cr_q[f][c] <= CROSS_W'(c_prod_q[f][2*c]) - CROSS_W'(c_prod_q[f][2*c+1]);
        end
      end
      d_ax_q  <= c_ax_q;
      d_deg_q <= c_deg_q;
    end
  end

  for (genvar f = 0; f < 2; f++) begin : g_frame
    tam_norm u_norm_first (
      .clk_i  (clk_i),
      .en_i   (en),
      .vec_i  (b_v1_q[f]),
      .axis_o (ax0[f])
    );

    tam_norm u_norm_cross (
      .clk_i  (clk_i),
      .en_i   (en),
      .vec_i  (b_cr_q[f]),
      .axis_o (ax1[f])
    );

    tam_norm u_norm_third (
      .clk_i  (clk_i),
      .en_i   (en),
      .vec_i  (d_cr_q[f]),
      .axis_o (ax2[f])
    );
  end

  // first two axes wait alongside the third normaliser
  logic [FLAT_W-1:0] d_flat;
  logic [FLAT_W-1:0] n2_flat;
  logic              n2_vld;
  logic              n2_deg;
  q14_t              frame_ax [2][3][3];

  always_comb begin
    for (int f = 0; f < 2; f++) begin
      for (int k = 0; k < 2; k++) begin
        for (int i = 0; i < 3; i++) begin
          d_flat[((f*2+k)*3+i)*Q14_W +: Q14_W] = d_ax_q[f][k][i];
        end
      end
    end
  end

  tam_dly #(
    .W (FLAT_W + 2),
    .N (NORM_LAT)
  ) u_dly_axes (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .d_i    ({d_vld_q, d_deg_q, d_flat}),
    .q_o    ({n2_vld, n2_deg, n2_flat})
  );

  always_comb begin
    for (int f = 0; f < 2; f++) begin
      for (int k = 0; k < 2; k++) begin
        for (int i = 0; i < 3; i++) begin
          frame_ax[f][k][i] = n2_flat[((f*2+k)*3+i)*Q14_W +: Q14_W];
        end
      end
      frame_ax[f][2] = ax2[f];
    end
  end

  // stage e: matrix product terms, r[i][j] = sum over k of p[k][i] * c[k][j]
  logic signed [PROD_W-1:0] e_prod_q [3][3][3];
  logic                     e_deg_q;
  logic                     e_vld_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          for (int k = 0; k < 3; k++) begin
            e_prod_q[i][j][k] <= frame_ax[0][k][i] * frame_ax[1][k][j];
          end
        end
      end
      e_deg_q <= n2_deg;
    end
  end

  // stage f: sum, round, clip, output register; a degenerate result is zeroed
  q14_t rot_q [3][3];
  logic deg_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          rot_q[i][j] <= e_deg_q ? '0
                       : round_sat(ACC_W'(e_prod_q[i][j][0]) + ACC_W'(e_prod_q[i][j][1])
                                   + ACC_W'(e_prod_q[i][j][2]));
        end
      end
      deg_q <= e_deg_q;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      b_vld_q   <= 1'b0;
      c_vld_q   <= 1'b0;
      d_vld_q   <= 1'b0;
      e_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q   <= in_valid_i;
      b_vld_q   <= a_vld_q;
      c_vld_q   <= n1_ctl[1];
      d_vld_q   <= c_vld_q;
      e_vld_q   <= n2_vld;
      out_vld_q <= e_vld_q;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign degenerate_o = deg_q;
  assign rot_00_o     = rot_q[0][0];
  assign rot_01_o     = rot_q[0][1];
  assign rot_02_o     = rot_q[0][2];
  assign rot_10_o     = rot_q[1][0];
  assign rot_11_o     = rot_q[1][1];
  assign rot_12_o     = rot_q[1][2];
  assign rot_20_o     = rot_q[2][0];
  assign rot_21_o     = rot_q[2][1];
  assign rot_22_o     = rot_q[2][2];

  // checks
  logic rot_all_zero;
  logic row0_nonzero;

  assign rot_all_zero = (rot_q[0][0] == '0) && (rot_q[0][1] == '0) && (rot_q[0][2] == '0)
                     && (rot_q[1][0] == '0) && (rot_q[1][1] == '0) && (rot_q[1][2] == '0)
                     && (rot_q[2][0] == '0) && (rot_q[2][1] == '0) && (rot_q[2][2] == '0);
  assign row0_nonzero = (rot_q[0][0] != '0) || (rot_q[0][1] != '0) || (rot_q[0][2] != '0);

`include "triad_attitude_matrix_top_macros.svh"

  `TAM_ASSERT(a_deg_zero, out_vld_q && deg_q |-> rot_all_zero, "degenerate result not zeroed")
  `TAM_ASSERT(a_row_unit, out_vld_q && !deg_q |-> row0_nonzero, "rotation row collapsed to zero")
  `TAM_ASSERT_NEXT(a_stall_hold, !en, $stable(b_vld_q) && $stable(e_vld_q), "stage moved in stall")

endmodule
